// ===== rtl/ajsc_pkg.sv =====
// shared types and constants for the adaptive job size controller
// no dependencies
package ajsc_pkg;

    localparam int unsigned TimeW   = 40;
    localparam int unsigned WeightW = 48;
    localparam int unsigned TotalW  = 64;
    localparam int unsigned CountW  = 32;
    localparam int unsigned RatioW  = 16;
    localparam int unsigned BoostW  = 12;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned ProdW   = TotalW + TimeW;

    localparam logic [CfgIdxW-1:0] CFG_MIN_EXEC = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_EXEC = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_RATIO    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_BOOST    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_INIT_W   = 3'd4;

    localparam logic [TimeW-1:0]   RST_MIN_EXEC = 40'd60000000;
    localparam logic [TimeW-1:0]   RST_MAX_EXEC = 40'd600000000;
    localparam logic [RatioW-1:0]  RST_RATIO    = 16'd5120;
    localparam logic [BoostW-1:0]  RST_BOOST    = 12'd512;
    localparam logic [WeightW-1:0] RST_INIT_W   = 48'd268435456;

    localparam logic [TimeW-1:0]   PER_BYTE_CAP = 40'd1000000000000;
    localparam logic [TimeW-1:0]   CAP_IDEAL_MAX = 40'd281;
    localparam logic [WeightW-1:0] WEIGHT_MAX = {WeightW{1'b1}};

    localparam logic [6:0] MEAN_ITERS  = 7'd64;
    localparam logic [6:0] QUOT_ITERS  = 7'd48;
    localparam logic [5:0] RATIO_ITERS = 6'd16;
    localparam logic [5:0] SCALE_ITERS = 6'd40;

    typedef struct packed {
        logic       start;
        logic [6:0] iters;
    } t_div_cmd;

    typedef struct packed {
        logic       start;
        logic [5:0] iters;
    } t_mul_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_RATIO_GO,
        S_RATIO_WAIT,
        S_CLAMP,
        S_SCALE_GO,
        S_SCALE_WAIT,
        S_QUOT_GO,
        S_QUOT_WAIT,
        S_LIMIT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/ajsc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on ajsc_pkg
module ajsc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ajsc_pkg::t_div_cmd i_cmd,
    input  logic [63:0]       i_rem_init,
    input  logic [63:0]       i_dividend,
    input  logic [63:0]       i_divisor,
    output logic              o_done,
    output logic [63:0]       o_quot
);

    logic [63:0] r_rem, r_dvd, r_dsr, r_quot;
    logic [6:0]  r_cnt;
    logic        r_done;
    logic [64:0] w_trial;
    logic [64:0] w_diff;
    logic        w_ge;

    assign w_trial = {r_rem, r_dvd[63]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_cmd.start) begin
            r_cnt  <= i_cmd.iters;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 7'd1);
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem  <= i_rem_init;
            r_dvd  <= i_dividend;
            r_dsr  <= i_divisor;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= w_ge ? w_diff[63:0] : w_trial[63:0];
            r_dvd  <= {r_dvd[62:0], 1'b0};
            r_quot <= {r_quot[62:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/ajsc_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on ajsc_pkg
module ajsc_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ajsc_pkg::t_mul_cmd i_cmd,
    input  logic [63:0]        i_mcand,
    input  logic [39:0]        i_mplier,
    output logic               o_done,
    output logic [103:0]       o_prod
);

    logic [63:0] r_hi, r_mcand;
    logic [39:0] r_lo;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [64:0] w_sum;

    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : 65'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_cmd.start) begin
            r_cnt  <= i_cmd.iters;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hi    <= '0;
            r_lo    <= i_mplier;
            r_mcand <= i_mcand;
        end else if (r_cnt != '0) begin
            r_hi <= w_sum[64:1];
            r_lo <= {w_sum[0], r_lo[39:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

// ===== rtl/adaptive_job_size_controller.sv =====
// channel  | dir | tdata (lsb first)                               | tuser
// s_axis   | in  | job_bytes, prepare_time, download_time, exec    | abandoned
// m_axis   | out | weight_per_job                                  | -
// a report with samples runs the mean divide, the ratio and scale serial multiplies
// and the weight divide in turn; the next report is accepted once the controller is
// back in idle
// an abandoned report or one with no samples yet goes from accumulate straight to
// done; synchronous active-low reset
// a finished result waits in the output register and stalls the input until free
// depends on ajsc_pkg, ajsc_div, ajsc_mul
module adaptive_job_size_controller (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,  // job_bytes, prepare, download, exec
    input  logic [0:0]   s_axis_tuser,  // abandoned
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,  // weight_per_job
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [47:0]  i_cfg_data
);

    ajsc_pkg::t_state   r_state, n_state;
    ajsc_pkg::t_div_cmd w_div_cmd;
    ajsc_pkg::t_mul_cmd w_mul_cmd;

    logic [39:0]  r_min_exec, r_max_exec;
    logic [15:0]  r_ratio;
    logic [11:0]  r_boost;
    logic [31:0]  r_count;
    logic [63:0]  r_tot_prep, r_tot_exec, r_tot_data;
    logic [47:0]  r_weight;
    logic         r_ab;
    logic [47:0]  r_in_data;
    logic [39:0]  r_in_prep, r_in_down, r_in_exec;
    logic [63:0]  r_mean;
    logic [39:0]  r_ideal;
    logic [47:0]  r_cap, r_upper;
    logic         r_sat;
    logic         r_out_valid;
    logic [47:0]  r_out_data;

    logic         w_sample;
    logic [39:0]  w_net;
    logic [31:0]  w_count_next;
    logic [64:0]  w_add_prep, w_add_exec, w_add_data;
    logic         w_div_done, w_mul_done;
    logic [63:0]  w_quot;
    logic [103:0] w_prod;
    logic [63:0]  w_div_rem, w_div_dvd, w_div_dsr;
    logic [63:0]  w_mul_mcand;
    logic [39:0]  w_mul_mplier;
    logic [79:0]  w_ratio_prod;
    logic [55:0]  w_ideal_raw, w_ideal_lo;
    logic [55:0]  w_ideal_cl;
    logic [47:0]  w_cap_full;
    logic [59:0]  w_boosted;
    logic [47:0]  w_q, w_w1, w_w2, w_w3;

    assign w_net    = r_in_prep - r_in_down;
    assign w_sample = !r_ab && (r_in_data != '0) && (r_in_prep > r_in_down)
                      && (r_in_exec != '0);
    assign w_count_next = (w_sample && r_count != '1) ? r_count + 32'd1 : r_count;
    assign w_add_prep = {1'b0, r_tot_prep} + {25'd0, w_net};
    assign w_add_exec = {1'b0, r_tot_exec} + {25'd0, r_in_exec};
    assign w_add_data = {1'b0, r_tot_data} + {17'd0, r_in_data};

    // divider and multiplier operand selection
    always_comb begin
        if (r_state == ajsc_pkg::S_MEAN_GO) begin
            w_div_rem = '0;
            w_div_dvd = r_tot_prep;
            w_div_dsr = {32'd0, r_count};
        end else begin
            w_div_rem = {8'd0, w_prod[103:48]};
            w_div_dvd = {w_prod[47:0], 16'd0};
            w_div_dsr = r_tot_exec;
        end
        if (r_state == ajsc_pkg::S_RATIO_GO) begin
            w_mul_mcand  = r_mean;
            w_mul_mplier = {24'd0, r_ratio};
        end else begin
            w_mul_mcand  = r_tot_data;
            w_mul_mplier = r_ideal;
        end
    end

    ajsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_div_cmd),
        .i_rem_init (w_div_rem),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    ajsc_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_mul_cmd),
        .i_mcand  (w_mul_mcand),
        .i_mplier (w_mul_mplier),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    // ideal exec time clamp
    assign w_ratio_prod = {w_prod[103:40], w_prod[39:24]};
    assign w_ideal_raw  = (w_ratio_prod[79:64] != '0) ? '1 : w_ratio_prod[63:8];
    assign w_ideal_lo   = (w_ideal_raw < {16'd0, r_min_exec}) ? {16'd0, r_min_exec}
                                                              : w_ideal_raw;
    assign w_ideal_cl   = (w_ideal_lo > {16'd0, r_max_exec}) ? {16'd0, r_max_exec}
                                                             : w_ideal_lo;

    // cap only matters while the ideal time is at most 281, which fits in 9 bits
    assign w_cap_full = {39'd0, r_ideal[8:0]} * {8'd0, ajsc_pkg::PER_BYTE_CAP};
    assign w_boosted  = {12'd0, r_weight} * {48'd0, r_boost};

    // final weight limits
    assign w_q  = r_sat ? ajsc_pkg::WEIGHT_MAX : w_quot[47:0];
    assign w_w1 = (w_q < r_cap) ? w_q : r_cap;
    assign w_w2 = (w_w1 > r_upper) ? r_upper : w_w1;
    assign w_w3 = (w_w2 < r_weight) ? r_weight : w_w2;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ajsc_pkg::S_IDLE:       if (s_axis_tvalid) n_state = ajsc_pkg::S_ACC;
            ajsc_pkg::S_ACC: begin
                if (r_ab || w_count_next == '0) begin
                    n_state = ajsc_pkg::S_DONE;
                end else begin
                    n_state = ajsc_pkg::S_MEAN_GO;
                end
            end
            ajsc_pkg::S_MEAN_GO:    n_state = ajsc_pkg::S_MEAN_WAIT;
            ajsc_pkg::S_MEAN_WAIT:  if (w_div_done) n_state = ajsc_pkg::S_RATIO_GO;
            ajsc_pkg::S_RATIO_GO:   n_state = ajsc_pkg::S_RATIO_WAIT;
            ajsc_pkg::S_RATIO_WAIT: if (w_mul_done) n_state = ajsc_pkg::S_CLAMP;
            ajsc_pkg::S_CLAMP:      n_state = ajsc_pkg::S_SCALE_GO;
            ajsc_pkg::S_SCALE_GO:   n_state = ajsc_pkg::S_SCALE_WAIT;
            ajsc_pkg::S_SCALE_WAIT: if (w_mul_done) n_state = ajsc_pkg::S_QUOT_GO;
            ajsc_pkg::S_QUOT_GO:    n_state = ajsc_pkg::S_QUOT_WAIT;
            ajsc_pkg::S_QUOT_WAIT:  if (w_div_done) n_state = ajsc_pkg::S_LIMIT;
            ajsc_pkg::S_LIMIT:      n_state = ajsc_pkg::S_DONE;
            ajsc_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) n_state = ajsc_pkg::S_IDLE;
            end
            default:                n_state = ajsc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_div_cmd.start = 1'b0;
        w_div_cmd.iters = ajsc_pkg::MEAN_ITERS;
        w_mul_cmd.start = 1'b0;
        w_mul_cmd.iters = ajsc_pkg::RATIO_ITERS;
        unique case (r_state)
            ajsc_pkg::S_MEAN_GO:  w_div_cmd.start = 1'b1;
            ajsc_pkg::S_QUOT_GO: begin
                w_div_cmd.start = 1'b1;
                w_div_cmd.iters = ajsc_pkg::QUOT_ITERS;
            end
            ajsc_pkg::S_RATIO_GO: w_mul_cmd.start = 1'b1;
            ajsc_pkg::S_SCALE_GO: begin
                w_mul_cmd.start = 1'b1;
                w_mul_cmd.iters = ajsc_pkg::SCALE_ITERS;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ajsc_pkg::S_IDLE;
            r_min_exec  <= ajsc_pkg::RST_MIN_EXEC;
            r_max_exec  <= ajsc_pkg::RST_MAX_EXEC;
            r_ratio     <= ajsc_pkg::RST_RATIO;
            r_boost     <= ajsc_pkg::RST_BOOST;
            r_weight    <= ajsc_pkg::RST_INIT_W;
            r_count     <= '0;
            r_tot_prep  <= '0;
            r_tot_exec  <= '0;
            r_tot_data  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ajsc_pkg::CFG_MIN_EXEC: r_min_exec <= i_cfg_data[39:0];
                    ajsc_pkg::CFG_MAX_EXEC: r_max_exec <= i_cfg_data[39:0];
                    ajsc_pkg::CFG_RATIO:    r_ratio    <= i_cfg_data[15:0];
                    ajsc_pkg::CFG_BOOST:    r_boost    <= i_cfg_data[11:0];
                    ajsc_pkg::CFG_INIT_W:   r_weight   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ajsc_pkg::S_ACC && w_sample) begin
                r_count    <= w_count_next;
                r_tot_prep <= w_add_prep[64] ? '1 : w_add_prep[63:0];
                r_tot_exec <= w_add_exec[64] ? '1 : w_add_exec[63:0];
                r_tot_data <= w_add_data[64] ? '1 : w_add_data[63:0];
            end
            if (r_state == ajsc_pkg::S_LIMIT) begin
                r_weight <= w_w3;
            end
            if (r_state == ajsc_pkg::S_DONE && n_state == ajsc_pkg::S_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ajsc_pkg::S_IDLE && s_axis_tvalid) begin
            r_ab      <= s_axis_tuser[0];
            r_in_data <= s_axis_tdata[47:0];
            r_in_prep <= s_axis_tdata[87:48];
            r_in_down <= s_axis_tdata[127:88];
            r_in_exec <= s_axis_tdata[167:128];
        end
        if (r_state == ajsc_pkg::S_MEAN_WAIT && w_div_done) begin
            r_mean <= w_quot;
        end
        if (r_state == ajsc_pkg::S_CLAMP) begin
            r_ideal <= w_ideal_cl[39:0];
        end
        if (r_state == ajsc_pkg::S_QUOT_GO) begin
            r_sat   <= {8'd0, w_prod[103:48]} >= r_tot_exec;
            r_cap   <= (r_ideal > ajsc_pkg::CAP_IDEAL_MAX) ? ajsc_pkg::WEIGHT_MAX
                                                           : w_cap_full;
            r_upper <= (w_boosted[59:56] != '0) ? ajsc_pkg::WEIGHT_MAX
                                                : w_boosted[55:8];
        end
        if (r_state == ajsc_pkg::S_DONE && n_state == ajsc_pkg::S_IDLE) begin
            r_out_data <= r_weight;
        end
    end

    assign s_axis_tready = (r_state == ajsc_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_accept_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == ajsc_pkg::S_ACC)
        else $error("accepted report did not enter accumulate");

    a_weight_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ajsc_pkg::S_LIMIT |=> r_weight >= $past(r_weight))
        else $error("weight shrank on update");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ajsc_pkg::S_DONE)
        else $error("result raised outside done state");

endmodule
